// ----- design/assert_macros.svh -----
// Assertion helpers for the checker. Each use expands to one labeled property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/m3i_pkg.sv -----
package m3i_pkg;

    localparam int ELEM_W = 32;
    localparam int N_ELEM = 9;
    localparam int ADJ_W  = 64;
    localparam int LO_W   = 65;
    localparam int PROD_W = 96;
    localparam int DET_W  = 98;
    localparam int QB     = 33;
    localparam int CFG_W  = 48;

    // Pipeline stage positions.
    localparam int ST_COF0 = 0;
    localparam int ST_COF1 = 1;
    localparam int ST_DET0 = 2;
    localparam int ST_PREP = 5;
    localparam int ST_DIV  = 6;
    localparam int ST_FIN  = ST_DIV + QB;
    localparam int NS      = ST_FIN + 1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t [N_ELEM-1:0] mat_t;
    typedef logic signed [ADJ_W-1:0] adj_t;
    typedef adj_t [N_ELEM-1:0] adjm_t;

    // Cofactor k is a[P]*a[Q] - a[R]*a[S].
    localparam logic [3:0] COF_P [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] COF_Q [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] COF_R [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] COF_S [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        logic [DET_W-1:0] rem;
        logic [QB-1:0]    bits;
        logic [QB-1:0]    quo;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        lane_t [N_ELEM-1:0] lane;
        logic [DET_W-1:0]   den;
        logic               singular;
    } div_t;

endpackage

// ----- design/m3i_cofactor.sv -----
module m3i_cofactor
(
    input  logic          clk,
    input  logic [1:0]    en,
    input  m3i_pkg::mat_t a,
    output m3i_pkg::adjm_t adj,
    output m3i_pkg::elem_t [2:0] a_top
);

    m3i_pkg::adjm_t pq_next, rs_next, pq_reg, rs_reg, adj_next, adj_reg;
    m3i_pkg::elem_t [2:0] top0_reg, top1_reg;

    always_comb
    begin
        for (int k = 0; k < m3i_pkg::N_ELEM; k++)
        begin
            pq_next[k] = m3i_pkg::ADJ_W'($signed(a[m3i_pkg::COF_P[k]]))
                       * m3i_pkg::ADJ_W'($signed(a[m3i_pkg::COF_Q[k]]));
            rs_next[k] = m3i_pkg::ADJ_W'($signed(a[m3i_pkg::COF_R[k]]))
                       * m3i_pkg::ADJ_W'($signed(a[m3i_pkg::COF_S[k]]));
            adj_next[k] = $signed(pq_reg[k]) - $signed(rs_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pq_reg   <= pq_next;
            rs_reg   <= rs_next;
            top0_reg <= a[2:0];
        end
        if (en[1])
        begin
            adj_reg  <= adj_next;
            top1_reg <= top0_reg;
        end
    end

    assign adj   = adj_reg;
    assign a_top = top1_reg;

endmodule

// ----- design/m3i_det.sv -----
module m3i_det
(
    input  logic                 clk,
    input  logic [2:0]           en,
    input  m3i_pkg::adjm_t       adj_in,
    input  m3i_pkg::elem_t [2:0] a_top,
    output m3i_pkg::adjm_t       adj_out,
    output logic [m3i_pkg::DET_W-1:0] det
);

    logic signed [m3i_pkg::LO_W-1:0]  lo_next [3];
    logic signed [m3i_pkg::LO_W-1:0]  lo_reg  [3];
    logic signed [m3i_pkg::ADJ_W-1:0] hi_next [3];
    logic signed [m3i_pkg::ADJ_W-1:0] hi_reg  [3];
    logic [m3i_pkg::PROD_W-1:0]       prod_next [3];
    logic [m3i_pkg::PROD_W-1:0]       prod_reg  [3];
    logic [m3i_pkg::DET_W-1:0]        det_next, det_reg;
    m3i_pkg::adjm_t adj0_reg, adj1_reg, adj2_reg;

    // The 32 by 64 products of the first-row expansion are split into two
    // 32 by 32 halves and joined one stage later.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_next[k] = m3i_pkg::LO_W'($signed(a_top[k]))
                       * $signed({1'b0, adj_in[3*k][31:0]});
            hi_next[k] = m3i_pkg::ADJ_W'($signed(a_top[k]))
                       * m3i_pkg::ADJ_W'($signed(adj_in[3*k][63:32]));
            prod_next[k] = {hi_reg[k], 32'b0}
                         + {{(m3i_pkg::PROD_W-m3i_pkg::LO_W){lo_reg[k][m3i_pkg::LO_W-1]}},
                            lo_reg[k]};
        end
        det_next = {{2{prod_reg[0][m3i_pkg::PROD_W-1]}}, prod_reg[0]}
                 + {{2{prod_reg[1][m3i_pkg::PROD_W-1]}}, prod_reg[1]}
                 + {{2{prod_reg[2][m3i_pkg::PROD_W-1]}}, prod_reg[2]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            adj0_reg <= adj_in;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
            adj1_reg <= adj0_reg;
        end
        if (en[2])
        begin
            det_reg  <= det_next;
            adj2_reg <= adj1_reg;
        end
    end

    assign det     = det_reg;
    assign adj_out = adj2_reg;

endmodule

// ----- design/m3i_prep.sv -----
module m3i_prep #(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          en,
    input  m3i_pkg::adjm_t                adj,
    input  logic [m3i_pkg::DET_W-1:0]     det,
    input  logic [m3i_pkg::CFG_W-1:0]     thr,
    output m3i_pkg::div_t                 d_out
);

    localparam int SH = 2 * FRAC_BITS;
    localparam int NW = m3i_pkg::ADJ_W + SH;
    localparam int HW = NW - m3i_pkg::QB;

    logic [m3i_pkg::DET_W-1:0] den;
    logic [m3i_pkg::ADJ_W-1:0] mag [m3i_pkg::N_ELEM];
    logic [NW-1:0]             num [m3i_pkg::N_ELEM];
    m3i_pkg::div_t             d_next, d_reg;

    always_comb
    begin
        den = det[m3i_pkg::DET_W-1] ? (~det + 1'b1) : det;
        d_next.den = den;
        d_next.singular = (den == '0)
                       || (den < {{(m3i_pkg::DET_W-m3i_pkg::CFG_W){1'b0}}, thr});
        for (int k = 0; k < m3i_pkg::N_ELEM; k++)
        begin
            mag[k] = adj[k][m3i_pkg::ADJ_W-1] ? (~adj[k] + 1'b1) : adj[k];
            num[k] = {mag[k], {SH{1'b0}}};
            // Quotients of 2^33 or more always clamp; below that the upper
            // part of the numerator is already smaller than the divisor.
            d_next.lane[k].rem  = {{(m3i_pkg::DET_W-HW){1'b0}}, num[k][NW-1:m3i_pkg::QB]};
            d_next.lane[k].bits = num[k][m3i_pkg::QB-1:0];
            d_next.lane[k].quo  = '0;
            d_next.lane[k].neg  = adj[k][m3i_pkg::ADJ_W-1] ^ det[m3i_pkg::DET_W-1];
            d_next.lane[k].ovf  = d_next.lane[k].rem >= den;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ----- design/m3i_div_step.sv -----
module m3i_div_step
(
    input  logic          clk,
    input  logic          en,
    input  m3i_pkg::div_t d_in,
    output m3i_pkg::div_t d_out
);

    logic [m3i_pkg::DET_W:0] r2   [m3i_pkg::N_ELEM];
    logic [m3i_pkg::DET_W:0] diff [m3i_pkg::N_ELEM];
    logic                    ge   [m3i_pkg::N_ELEM];
    m3i_pkg::div_t           d_next, d_reg;

    // One restoring step per lane: shift in the next numerator bit, subtract
    // the divisor where it fits.
    always_comb
    begin
        d_next = d_in;
        for (int k = 0; k < m3i_pkg::N_ELEM; k++)
        begin
            r2[k]   = {d_in.lane[k].rem, d_in.lane[k].bits[m3i_pkg::QB-1]};
            diff[k] = r2[k] - {1'b0, d_in.den};
            ge[k]   = r2[k] >= {1'b0, d_in.den};
            d_next.lane[k].rem  = ge[k] ? diff[k][m3i_pkg::DET_W-1:0]
                                        : r2[k][m3i_pkg::DET_W-1:0];
            d_next.lane[k].bits = {d_in.lane[k].bits[m3i_pkg::QB-2:0], 1'b0};
            d_next.lane[k].quo  = {d_in.lane[k].quo[m3i_pkg::QB-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ----- design/m3i_finish.sv -----
module m3i_finish #(
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          en,
    input  m3i_pkg::div_t d_in,
    output m3i_pkg::mat_t r,
    output logic          singular,
    output logic          saturated
);

    localparam int QW = m3i_pkg::QB + 1;
    localparam logic [QW-1:0] LIM_POS = QW'(32'h7FFF_FFFF);
    localparam logic [QW-1:0] LIM_NEG = QW'(32'h8000_0000);
    localparam logic [m3i_pkg::ELEM_W-1:0] ONE = m3i_pkg::ELEM_W'(1) << FRAC_BITS;

    logic [QW-1:0]             q     [m3i_pkg::N_ELEM];
    logic [QW-1:0]             lim   [m3i_pkg::N_ELEM];
    logic [QW-1:0]             val   [m3i_pkg::N_ELEM];
    logic                      up    [m3i_pkg::N_ELEM];
    logic                      clamp [m3i_pkg::N_ELEM];
    logic [m3i_pkg::ELEM_W-1:0] res  [m3i_pkg::N_ELEM];
    m3i_pkg::mat_t             r_next, r_reg;
    logic                      sat_next, sat_reg, sing_reg;

    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < m3i_pkg::N_ELEM; k++)
        begin
            // Round half away from zero on the magnitude.
            up[k]    = {d_in.lane[k].rem, 1'b0} >= {1'b0, d_in.den};
            q[k]     = {1'b0, d_in.lane[k].quo} + QW'(up[k]);
            lim[k]   = d_in.lane[k].neg ? LIM_NEG : LIM_POS;
            clamp[k] = d_in.lane[k].ovf || (q[k] > lim[k]);
            val[k]   = clamp[k] ? lim[k] : q[k];
            res[k]   = d_in.lane[k].neg ? (~val[k][m3i_pkg::ELEM_W-1:0] + 1'b1)
                                        : val[k][m3i_pkg::ELEM_W-1:0];
            sat_next = sat_next | clamp[k];
            if (d_in.singular)
            begin
                r_next[k] = (k % 4 == 0) ? ONE : '0;
            end
            else
            begin
                r_next[k] = res[k];
            end
        end
        if (d_in.singular)
        begin
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_next;
            sat_reg  <= sat_next;
            sing_reg <= d_in.singular;
        end
    end

    assign r         = r_reg;
    assign singular  = sing_reg;
    assign saturated = sat_reg;

endmodule

// ----- design/matrix3_inverse.sv -----
// 3x3 matrix inverse by cofactors over the determinant, Q16.16 in and out.
// The pipeline holds the 33 one-bit quotient steps of the nine parallel
// restoring dividers plus 7 stages.
// Throughput: one matrix per cycle; stages hold their data while the output stalls.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the
// singular threshold to 1.
module matrix3_inverse #(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic [1:0]   m_tuser    // singular, saturated
);

    logic [m3i_pkg::NS-1:0]    v_reg, v_next, ok;
    logic [m3i_pkg::CFG_W-1:0] thr_reg;

    m3i_pkg::mat_t              a, r;
    m3i_pkg::adjm_t             adj_c, adj_d;
    m3i_pkg::elem_t [2:0]       a_top;
    logic [m3i_pkg::DET_W-1:0]  det;
    m3i_pkg::div_t              dv [m3i_pkg::QB+1];
    logic                       singular, saturated;

    // A stage may load when it is empty or when everything after it can move.
    genvar i;
    generate
        for (i = 0; i < m3i_pkg::NS; i++)
        begin : g_ok
            assign ok[i] = m_tready || !(&v_reg[m3i_pkg::NS-1:i]);
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < m3i_pkg::NS; k++)
        begin
            if (ok[k])
            begin
                v_next[k] = (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k-1];
            end
            else
            begin
                v_next[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            thr_reg <= m3i_pkg::CFG_W'(1);
        end
        else
        begin
            v_reg <= v_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    assign a = s_tdata;

    m3i_cofactor u_cof (
        .clk   (clk),
        .en    (ok[m3i_pkg::ST_COF1:m3i_pkg::ST_COF0]),
        .a     (a),
        .adj   (adj_c),
        .a_top (a_top)
    );

    m3i_det u_det (
        .clk     (clk),
        .en      (ok[m3i_pkg::ST_DET0+2:m3i_pkg::ST_DET0]),
        .adj_in  (adj_c),
        .a_top   (a_top),
        .adj_out (adj_d),
        .det     (det)
    );

    m3i_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk   (clk),
        .en    (ok[m3i_pkg::ST_PREP]),
        .adj   (adj_d),
        .det   (det),
        .thr   (thr_reg),
        .d_out (dv[0])
    );

    genvar j;
    generate
        for (j = 0; j < m3i_pkg::QB; j++)
        begin : g_div
            m3i_div_step u_step (
                .clk   (clk),
                .en    (ok[m3i_pkg::ST_DIV+j]),
                .d_in  (dv[j]),
                .d_out (dv[j+1])
            );
        end
    endgenerate

    m3i_finish #(.FRAC_BITS(FRAC_BITS)) u_fin (
        .clk       (clk),
        .en        (ok[m3i_pkg::ST_FIN]),
        .d_in      (dv[m3i_pkg::QB]),
        .r         (r),
        .singular  (singular),
        .saturated (saturated)
    );

    assign s_tready = ok[0];
    assign m_tvalid = v_reg[m3i_pkg::NS-1];
    assign m_tdata  = r;
    assign m_tuser  = {saturated, singular};

endmodule

// ----- design/m3i_checker.sv -----
`include "assert_macros.svh"

module m3i_props #(
    parameter int FRAC_BITS = 16
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [287:0] m_tdata,
    input logic [1:0]   m_tuser
);

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic ident_ok;

    assign ident_ok = (m_tdata[31:0] == ONE) && (m_tdata[63:32] == 32'd0)
                   && (m_tdata[159:128] == ONE);

    // A singular result is the plain identity and never reports clamping.
    `CHK_IMPLY(a_sing_nosat, m_tvalid && m_tuser[0], !m_tuser[1])
    `CHK_IMPLY(a_sing_ident, m_tvalid && m_tuser[0], ident_ok)
    // With the output stage empty the pipeline has room for a transfer.
    `CHK_IMPLY(a_room, !m_tvalid, s_tready)
    `CHK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind matrix3_inverse m3i_props #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);
